// ===== rtl/bqvc_pkg.sv =====
package bqvc_pkg;

   // defaults for the top level parameters
   localparam int STACK_DEPTH_DEFAULT = 16;
   localparam int POS_WIDTH_DEFAULT   = 16;

   // entries in the queue between scanner and result stage
   localparam int QUEUE_DEPTH = 4;

   // characters the scanner reacts to
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_VT      = 8'h0B;
   localparam logic [7:0] CH_FF      = 8'h0C;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_SQUOTE  = 8'h27;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CH_RBRACK  = 8'h5D;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;

   typedef enum logic [3:0] {
      ERR_NONE      = 4'd0,
      ERR_UNM_PAREN = 4'd1,
      ERR_UNM_BRACK = 4'd2,
      ERR_UNM_BRACE = 4'd3,
      ERR_EXP_PAREN = 4'd4,
      ERR_EXP_BRACK = 4'd5,
      ERR_EXP_BRACE = 4'd6,
      ERR_OPEN_STR  = 4'd7,
      ERR_OPEN_CMT  = 4'd8,
      ERR_OVERFLOW  = 4'd9
   } err_type;

   typedef enum logic [1:0] {
      KIND_PAREN = 2'd0,
      KIND_BRACK = 2'd1,
      KIND_BRACE = 2'd2
   } kind_type;

   // string mode, one-hot
   typedef enum logic [2:0] {
      QM_NONE   = 3'b001,
      QM_DOUBLE = 3'b010,
      QM_SINGLE = 3'b100
   } quote_type;

   // pending lookahead, one-hot
   typedef enum logic [6:0] {
      LA_NONE  = 7'b0000001,
      LA_SLASH = 7'b0000010,
      LA_LINE  = 7'b0000100,
      LA_BLOCK = 7'b0001000,
      LA_STAR  = 7'b0010000,
      LA_QUOTE = 7'b0100000,
      LA_ESC   = 7'b1000000
   } la_type;

   typedef struct packed {
      logic        has_byte;
      logic [7:0]  value_byte;
      logic        terminated;
      logic [3:0]  error_code;
      logic [15:0] error_pos;
      logic [15:0] error_len;
   } rec_type;

   // results caused by one input byte, one or two
   typedef struct packed {
      logic    dual;
      rec_type first;
      rec_type second;
   } entry_type;

   typedef struct packed {
      logic stack_empty;
      logic in_string;
      logic pending;
   } front_stat_type;

   function automatic kind_type char_kind(input logic [7:0] b);
      kind_type k;
      case (b)
         CH_LPAREN, CH_RPAREN: k = KIND_PAREN;
         CH_LBRACK, CH_RBRACK: k = KIND_BRACK;
         default:              k = KIND_BRACE;
      endcase
      return k;
   endfunction

   function automatic err_type unmatched_code(input kind_type k);
      err_type e;
      case (k)
         KIND_PAREN: e = ERR_UNM_PAREN;
         KIND_BRACK: e = ERR_UNM_BRACK;
         default:    e = ERR_UNM_BRACE;
      endcase
      return e;
   endfunction

   function automatic err_type expected_code(input kind_type k);
      err_type e;
      case (k)
         KIND_PAREN: e = ERR_EXP_PAREN;
         KIND_BRACK: e = ERR_EXP_BRACK;
         default:    e = ERR_EXP_BRACE;
      endcase
      return e;
   endfunction

endpackage

// ===== rtl/bqvc_if.sv =====
// input byte channel
interface bqvc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

// result channel
interface bqvc_rsp_if;
   logic        valid;
   logic        ready;
   logic        has_byte;
   logic [7:0]  value_byte;
   logic        terminated;
   logic [3:0]  error_code;
   logic [15:0] error_pos;
   logic [15:0] error_len;
   logic        last_result;

   modport source (output valid, output has_byte, output value_byte, output terminated,
                   output error_code, output error_pos, output error_len,
                   output last_result, input ready);
   modport sink (input valid, input has_byte, input value_byte, input terminated,
                 input error_code, input error_pos, input error_len,
                 input last_result, output ready);
endinterface

// configuration write channel
interface bqvc_csr_if;
   logic valid;
   logic ready;
   logic at_mode;

   modport source (output valid, output at_mode, input ready);
   modport sink (input valid, input at_mode, output ready);
endinterface

// ===== rtl/bqvc_ram.sv =====
module bqvc_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bqvc_front.sv =====
module bqvc_front import bqvc_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT,
   parameter int POS_WIDTH   = POS_WIDTH_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           at_mode,
   input  logic           accept,
   input  logic [7:0]     text_byte,
   input  logic           end_of_text,
   output logic           push,
   output entry_type      entry,
   output front_stat_type stat
);

   localparam int PW = POS_WIDTH;
   localparam int DW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);
   localparam int EW = 2 + PW;

   // scan state
   logic [DW-1:0] depth_ff, depth_in;
   quote_type     quote_ff, quote_in;
   logic [PW-1:0] qstart_ff, qstart_in;
   la_type        la_ff, la_in;
   logic [PW-1:0] off_ff, off_in;
   kind_type      top_kind_ff, top_kind_in;
   logic [PW-1:0] top_pos_ff, top_pos_in;
   logic          fwd_ff, fwd_in;
   logic [EW-1:0] fwd_data_ff;

   // stack memory below the top entry
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [EW-1:0] ram_wdata, ram_rdata;
   logic [DW-1:0] depth_m1, depth_m2;
   logic [EW-1:0] below_data;
   kind_type      below_kind;
   logic [PW-1:0] below_pos;

   logic          depth_zero, depth_full;
   logic [PW-1:0] off_inc;
   quote_type     qm_eff;
   kind_type      b_kind;

   // plain byte handling
   logic          p_emit, p_clear, p_empty, p_push, p_pop;
   rec_type       p_rec;
   quote_type     p_quote;
   logic [PW-1:0] p_qstart;
   la_type        p_la;
   logic [PW-1:0] p_off;

   logic          use_plain, do_push;
   logic          a_valid, b_valid;
   rec_type       a_rec, b_rec;

   assign depth_zero = (depth_ff == '0);
   assign depth_full = (depth_ff >= DW'(STACK_DEPTH));
   assign off_inc    = off_ff + PW'(1);
   assign qm_eff     = (la_ff == LA_QUOTE) ? QM_NONE : quote_ff;
   assign b_kind     = char_kind(text_byte);

   // entry just below the top, with bypass of a same-cycle write
   assign below_data = fwd_ff ? fwd_data_ff : ram_rdata;
   assign below_kind = kind_type'(below_data[EW-1 -: 2]);
   assign below_pos  = below_data[PW-1:0];

   // byte with no lookahead pending
   always_comb begin
      p_emit   = 1'b1;
      p_clear  = 1'b0;
      p_empty  = 1'b0;
      p_push   = 1'b0;
      p_pop    = 1'b0;
      p_rec    = '0;
      p_quote  = qm_eff;
      p_qstart = qstart_ff;
      p_la     = LA_NONE;
      p_off    = off_ff;
      if (qm_eff == QM_NONE && depth_zero &&
          ((text_byte inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR}) ||
           (text_byte == CH_RBRACK && !at_mode))) begin
         p_clear = 1'b1;
         p_rec.terminated = 1'b1;
      end else if (qm_eff == QM_NONE && text_byte == CH_SLASH) begin
         p_emit = 1'b0;
         p_la   = LA_SLASH;
         p_off  = off_inc;
      end else begin
         p_off = off_inc;
         p_rec.has_byte   = 1'b1;
         p_rec.value_byte = text_byte;
         case (qm_eff)
            QM_SINGLE: begin
               if (text_byte == CH_BSLASH) begin
                  p_la = LA_ESC;
               end else if (text_byte == CH_SQUOTE) begin
                  p_quote = QM_NONE;
               end
            end
            QM_DOUBLE: begin
               if (text_byte == CH_DQUOTE) begin
                  p_la = LA_QUOTE;
               end
            end
            default: begin
               if (text_byte == CH_DQUOTE || text_byte == CH_SQUOTE) begin
                  p_quote  = (text_byte == CH_DQUOTE) ? QM_DOUBLE : QM_SINGLE;
                  p_qstart = off_ff;
               end else if (text_byte inside {CH_LPAREN, CH_LBRACK, CH_LBRACE}) begin
                  if (depth_full) begin
                     p_rec.error_code = ERR_OVERFLOW;
                     p_rec.error_pos  = 16'(off_ff);
                     p_rec.error_len  = 16'd1;
                  end else begin
                     p_push = 1'b1;
                  end
               end else if (text_byte inside {CH_RPAREN, CH_RBRACK, CH_RBRACE}) begin
                  if (depth_zero) begin
                     p_rec.error_code = unmatched_code(b_kind);
                     p_rec.error_pos  = 16'(off_ff);
                     p_rec.error_len  = 16'd1;
                  end else if (top_kind_ff == b_kind) begin
                     p_pop = 1'b1;
                  end else begin
                     p_rec.error_code = expected_code(top_kind_ff);
                     p_rec.error_pos  = 16'(off_ff);
                     p_rec.error_len  = 16'd1;
                  end
               end else if (text_byte == CH_SEMI && !depth_zero) begin
                  p_rec.error_code = expected_code(top_kind_ff);
                  p_rec.error_pos  = 16'(off_ff);
                  p_rec.error_len  = 16'd1;
                  p_empty = 1'b1;
               end
            end
         endcase
      end
   end

   // lookahead dispatch, end of text and next state
   always_comb begin
      depth_in    = depth_ff;
      quote_in    = quote_ff;
      qstart_in   = qstart_ff;
      la_in       = la_ff;
      off_in      = off_ff;
      top_kind_in = top_kind_ff;
      top_pos_in  = top_pos_ff;
      use_plain   = 1'b0;
      do_push     = 1'b0;
      a_valid     = 1'b0;
      a_rec       = '0;
      b_valid     = 1'b0;
      b_rec       = '0;
      if (accept) begin
         if (end_of_text) begin
            if (la_ff == LA_SLASH) begin
               a_valid = 1'b1;
               a_rec.has_byte   = 1'b1;
               a_rec.value_byte = CH_SLASH;
            end else if (la_ff == LA_BLOCK || la_ff == LA_STAR) begin
               a_valid = 1'b1;
               a_rec.error_code = ERR_OPEN_CMT;
               a_rec.error_pos  = 16'(off_ff - PW'(2));
               a_rec.error_len  = 16'd1;
            end
            if (qm_eff != QM_NONE) begin
               b_valid = 1'b1;
               b_rec.error_code = ERR_OPEN_STR;
               b_rec.error_pos  = 16'(qstart_ff);
               b_rec.error_len  = 16'(off_ff - qstart_ff);
            end else if (!depth_zero) begin
               b_valid = 1'b1;
               b_rec.error_code = expected_code(top_kind_ff);
               b_rec.error_pos  = 16'(top_pos_ff);
               b_rec.error_len  = 16'(off_ff - top_pos_ff);
            end
            depth_in  = '0;
            quote_in  = QM_NONE;
            qstart_in = '0;
            la_in     = LA_NONE;
            off_in    = '0;
         end else begin
            case (la_ff)
               LA_SLASH: begin
                  if (text_byte == CH_SLASH || text_byte == CH_STAR) begin
                     la_in  = (text_byte == CH_SLASH) ? LA_LINE : LA_BLOCK;
                     off_in = off_inc;
                  end else begin
                     // lone slash goes out ahead of this byte
                     a_valid = 1'b1;
                     a_rec.has_byte   = 1'b1;
                     a_rec.value_byte = CH_SLASH;
                     use_plain = 1'b1;
                  end
               end
               LA_LINE: begin
                  if (text_byte == CH_LF || text_byte == CH_CR) begin
                     use_plain = 1'b1;
                  end else begin
                     off_in = off_inc;
                  end
               end
               LA_BLOCK, LA_STAR: begin
                  off_in = off_inc;
                  if (text_byte == CH_STAR) begin
                     la_in = LA_STAR;
                  end else if (la_ff == LA_STAR && text_byte == CH_SLASH) begin
                     la_in = LA_NONE;
                  end else begin
                     la_in = LA_BLOCK;
                  end
               end
               LA_QUOTE: begin
                  if (text_byte == CH_DQUOTE) begin
                     la_in  = LA_NONE;
                     off_in = off_inc;
                     b_valid = 1'b1;
                     b_rec.has_byte   = 1'b1;
                     b_rec.value_byte = text_byte;
                  end else begin
                     use_plain = 1'b1;
                  end
               end
               LA_ESC: begin
                  la_in  = LA_NONE;
                  off_in = off_inc;
                  b_valid = 1'b1;
                  b_rec.has_byte   = 1'b1;
                  b_rec.value_byte = text_byte;
               end
               default: begin
                  use_plain = 1'b1;
               end
            endcase
         end
         if (use_plain) begin
            b_valid   = p_emit;
            b_rec     = p_rec;
            quote_in  = p_quote;
            qstart_in = p_qstart;
            la_in     = p_la;
            off_in    = p_off;
            if (p_clear) begin
               depth_in  = '0;
               quote_in  = QM_NONE;
               qstart_in = '0;
               la_in     = LA_NONE;
               off_in    = '0;
            end else if (p_empty) begin
               depth_in = '0;
            end else if (p_push) begin
               do_push     = 1'b1;
               depth_in    = depth_ff + DW'(1);
               top_kind_in = b_kind;
               top_pos_in  = off_ff;
            end else if (p_pop) begin
               depth_in    = depth_ff - DW'(1);
               top_kind_in = below_kind;
               top_pos_in  = below_pos;
            end
         end
      end
   end

   // pack results for the queue
   always_comb begin
      push         = a_valid || b_valid;
      entry.dual   = a_valid && b_valid;
      entry.first  = a_valid ? a_rec : b_rec;
      entry.second = b_rec;
   end

   // old top goes to memory on push, reads track the entry below the new top
   assign depth_m1  = depth_ff - DW'(1);
   assign depth_m2  = depth_in - DW'(2);
   assign ram_we    = do_push && !depth_zero;
   assign ram_waddr = depth_m1[AW-1:0];
   assign ram_wdata = {top_kind_ff, top_pos_ff};
   assign ram_raddr = depth_m2[AW-1:0];
   assign fwd_in    = ram_we && (ram_waddr == ram_raddr);

   bqvc_ram #(
      .WIDTH (EW),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff  <= '0;
         quote_ff  <= QM_NONE;
         qstart_ff <= '0;
         la_ff     <= LA_NONE;
         off_ff    <= '0;
         fwd_ff    <= 1'b0;
      end else begin
         depth_ff  <= depth_in;
         quote_ff  <= quote_in;
         qstart_ff <= qstart_in;
         la_ff     <= la_in;
         off_ff    <= off_in;
         fwd_ff    <= fwd_in;
      end
   end

   // top of stack and bypass data
   always_ff @(posedge clock) begin
      top_kind_ff <= top_kind_in;
      top_pos_ff  <= top_pos_in;
      fwd_data_ff <= ram_wdata;
   end

   assign stat.stack_empty = depth_zero;
   assign stat.in_string   = (quote_ff != QM_NONE);
   assign stat.pending     = (la_ff != LA_NONE);

endmodule

// ===== rtl/bqvc_queue.sv =====
module bqvc_queue import bqvc_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output logic      full,
   output logic      empty
);

   localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW   = $clog2(DEPTH + 1);

   entry_type       slot_ff [DEPTH];
   logic [PTRW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTRW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTRW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTRW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/bqvc_back.sv =====
module bqvc_back import bqvc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  entry_type head,
   input  logic      empty,
   input  logic      out_ready,
   output logic      out_valid,
   output rec_type   out_rec,
   output logic      out_last,
   output logic      pop
);

   logic sel_ff, sel_in;
   logic beat;

   // walk the one or two results of the head entry
   assign out_valid = !empty;
   assign out_rec   = sel_ff ? head.second : head.first;
   assign out_last  = sel_ff || !head.dual;
   assign beat      = out_valid && out_ready;
   assign pop       = beat && out_last;

   always_comb begin
      sel_in = sel_ff;
      if (beat) begin
         sel_in = !out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= 1'b0;
      end else begin
         sel_ff <= sel_in;
      end
   end

endmodule

// ===== rtl/bracket_quote_value_checker_core.sv =====
// a byte's results enter the result queue at its beat and leave from the queue head
// throughput: one byte per cycle while the queue is not full; a byte's two results
// go out one after the other, and the queue lets input run on while results wait
// bytes inside comments or a pending slash give no result
// reset: synchronous, active high; clears scan state, queue and at_mode,
// the bracket stack memory is not cleared and needs no clearing pass
module bracket_quote_value_checker_core import bqvc_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT,
   parameter int POS_WIDTH   = POS_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   bqvc_req_if.sink    req_if,
   bqvc_rsp_if.source  rsp_if,
   bqvc_csr_if.sink    csr_if
);

   logic           at_mode_ff, at_mode_in;
   logic           req_beat;
   logic           q_push, q_pop, q_full, q_empty;
   entry_type      q_in, q_head;
   front_stat_type front_stat;
   rec_type        out_rec;
   logic           out_valid, out_last;

   // configuration register
   assign csr_if.ready = 1'b1;
   assign at_mode_in   = (csr_if.valid && csr_if.ready) ? csr_if.at_mode : at_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         at_mode_ff <= 1'b0;
      end else begin
         at_mode_ff <= at_mode_in;
      end
   end

   // input side
   assign req_if.ready = !q_full;
   assign req_beat     = req_if.valid && req_if.ready;

   bqvc_front #(
      .STACK_DEPTH (STACK_DEPTH),
      .POS_WIDTH   (POS_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .at_mode     (at_mode_ff),
      .accept      (req_beat),
      .text_byte   (req_if.text_byte),
      .end_of_text (req_if.end_of_text),
      .push        (q_push),
      .entry       (q_in),
      .stat        (front_stat)
   );

   bqvc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in),
      .pop        (q_pop),
      .head       (q_head),
      .full       (q_full),
      .empty      (q_empty)
   );

   bqvc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .empty     (q_empty),
      .out_ready (rsp_if.ready),
      .out_valid (out_valid),
      .out_rec   (out_rec),
      .out_last  (out_last),
      .pop       (q_pop)
   );

   // output side
   assign rsp_if.valid       = out_valid;
   assign rsp_if.has_byte    = out_rec.has_byte;
   assign rsp_if.value_byte  = out_rec.value_byte;
   assign rsp_if.terminated  = out_rec.terminated;
   assign rsp_if.error_code  = out_rec.error_code;
   assign rsp_if.error_pos   = out_rec.error_pos;
   assign rsp_if.error_len   = out_rec.error_len;
   assign rsp_if.last_result = out_last;

   // end of text leaves a clean scanner
   assert property (@(posedge clock) disable iff (reset)
      (req_beat && req_if.end_of_text) |=>
         (front_stat.stack_empty && !front_stat.in_string && !front_stat.pending))
      else $error("scan state not cleared after end of text");

   // second result of a byte follows right after the first
   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.ready && !rsp_if.last_result) |=> rsp_if.valid)
      else $error("second result missing");

   // input stalls only while results are waiting
   assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> rsp_if.valid)
      else $error("input stalled with no result pending");

   // a termination carries no byte and no error
   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.terminated) |->
         (!rsp_if.has_byte && rsp_if.error_code == ERR_NONE))
      else $error("termination result carries payload");

endmodule

// ===== tb/sv/value_scan_checker.sv =====
`timescale 1ns / 1ps

module value_scan_checker import bqvc_pkg::*; (
   input  logic clock,
   input  logic reset,
   bqvc_req_if  req_mon,
   bqvc_rsp_if  rsp_mon,
   bqvc_csr_if  csr_mon,
   output int   error_count,
   output int   pending_results
);

   localparam int STACK_LIMIT = STACK_DEPTH_DEFAULT;

   typedef struct {
      logic        has_byte;
      logic [7:0]  value_byte;
      logic        terminated;
      err_type     error_code;
      logic [15:0] error_pos;
      logic [15:0] error_len;
      logic        last_result;
   } scan_result_type;

   // results still owed by the block, oldest first
   scan_result_type expected_results[$];

   // shadow of the scan state
   logic        at_mode_copy;
   kind_type    open_kinds [STACK_LIMIT];
   logic [15:0] open_positions [STACK_LIMIT];
   logic [4:0]  open_depth;
   quote_type   quoting;
   logic [15:0] quote_origin;
   la_type      pending_la;
   logic [15:0] scan_offset;

   function automatic void expect_result(input logic has, input logic [7:0] b,
                                         input logic term, input err_type code,
                                         input logic [15:0] pos, input logic [15:0] len);
      scan_result_type r;
      r.has_byte    = has;
      r.value_byte  = b;
      r.terminated  = term;
      r.error_code  = code;
      r.error_pos   = pos;
      r.error_len   = len;
      r.last_result = 1'b0;
      expected_results.insert(expected_results.size(), r);
   endfunction

   function automatic void restart_value();
      open_depth   = '0;
      quoting      = QM_NONE;
      quote_origin = '0;
      pending_la   = LA_NONE;
      scan_offset  = '0;
   endfunction

   function automatic bit is_blank(input logic [7:0] b);
      return b inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
   endfunction

   function automatic kind_type kind_of_bracket(input logic [7:0] b);
      if (b == CH_LPAREN || b == CH_RPAREN) return KIND_PAREN;
      if (b == CH_LBRACK || b == CH_RBRACK) return KIND_BRACK;
      return KIND_BRACE;
   endfunction

   function automatic kind_type top_kind();
      return open_kinds[open_depth - 5'd1];
   endfunction

   function automatic err_type closer_missing(input kind_type k);
      case (k)
         KIND_PAREN: return ERR_EXP_PAREN;
         KIND_BRACK: return ERR_EXP_BRACK;
         default:    return ERR_EXP_BRACE;
      endcase
   endfunction

   function automatic err_type closer_unmatched(input kind_type k);
      case (k)
         KIND_PAREN: return ERR_UNM_PAREN;
         KIND_BRACK: return ERR_UNM_BRACK;
         default:    return ERR_UNM_BRACE;
      endcase
   endfunction

   // byte with nothing pending
   function automatic void scan_plain(input logic [7:0] b);
      logic [15:0] pos;
      err_type     code;
      logic [15:0] epos;
      logic [15:0] elen;
      kind_type    k;
      code = ERR_NONE;
      epos = '0;
      elen = '0;
      if (quoting == QM_NONE) begin
         if (open_depth == 0 && (is_blank(b) || (b == CH_RBRACK && !at_mode_copy))) begin
            restart_value();
            expect_result(1'b0, 8'h00, 1'b1, ERR_NONE, 16'd0, 16'd0);
            return;
         end
         if (b == CH_SLASH) begin
            pending_la = LA_SLASH;
            scan_offset++;
            return;
         end
      end
      pos = scan_offset;
      scan_offset++;
      if (quoting == QM_SINGLE) begin
         if (b == CH_BSLASH)
            pending_la = LA_ESC;
         else if (b == CH_SQUOTE)
            quoting = QM_NONE;
      end else if (quoting == QM_DOUBLE) begin
         if (b == CH_DQUOTE)
            pending_la = LA_QUOTE;
      end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
         quoting      = (b == CH_DQUOTE) ? QM_DOUBLE : QM_SINGLE;
         quote_origin = pos;
      end else if (b == CH_LPAREN || b == CH_LBRACK || b == CH_LBRACE) begin
         if (open_depth >= STACK_LIMIT) begin
            code = ERR_OVERFLOW;
            epos = pos;
            elen = 16'd1;
         end else begin
            open_kinds[open_depth[3:0]]     = kind_of_bracket(b);
            open_positions[open_depth[3:0]] = pos;
            open_depth++;
         end
      end else if (b == CH_RPAREN || b == CH_RBRACK || b == CH_RBRACE) begin
         k = kind_of_bracket(b);
         if (open_depth == 0) begin
            code = closer_unmatched(k);
            epos = pos;
            elen = 16'd1;
         end else if (top_kind() == k) begin
            open_depth--;
         end else begin
            code = closer_missing(top_kind());
            epos = pos;
            elen = 16'd1;
         end
      end else if (b == CH_SEMI && open_depth > 0) begin
         // semicolon inside brackets names the top closer and drops the stack
         code       = closer_missing(top_kind());
         epos       = pos;
         elen       = 16'd1;
         open_depth = '0;
      end
      expect_result(1'b1, b, 1'b0, code, epos, elen);
   endfunction

   // end of text: settle what is pending, then report what is still open
   function automatic void flush_value();
      logic [15:0] p;
      if (pending_la == LA_SLASH)
         expect_result(1'b1, CH_SLASH, 1'b0, ERR_NONE, 16'd0, 16'd0);
      else if (pending_la == LA_QUOTE)
         quoting = QM_NONE;
      else if (pending_la == LA_BLOCK || pending_la == LA_STAR)
         expect_result(1'b0, 8'h00, 1'b0, ERR_OPEN_CMT, scan_offset - 16'd2, 16'd1);
      if (quoting != QM_NONE) begin
         expect_result(1'b0, 8'h00, 1'b0, ERR_OPEN_STR, quote_origin,
                       scan_offset - quote_origin);
      end else if (open_depth > 0) begin
         p = open_positions[open_depth - 5'd1];
         expect_result(1'b0, 8'h00, 1'b0, closer_missing(top_kind()), p, scan_offset - p);
      end
      restart_value();
   endfunction

   function automatic void scan_item(input logic [7:0] b, input logic eot);
      int count_prior;
      count_prior = expected_results.size();
      if (eot) begin
         flush_value();
      end else begin
         case (pending_la)
            LA_SLASH: begin
               if (b == CH_SLASH || b == CH_STAR) begin
                  pending_la = (b == CH_SLASH) ? LA_LINE : LA_BLOCK;
                  scan_offset++;
               end else begin
                  // lone slash goes out ahead of this byte
                  pending_la = LA_NONE;
                  expect_result(1'b1, CH_SLASH, 1'b0, ERR_NONE, 16'd0, 16'd0);
                  scan_plain(b);
               end
            end
            LA_LINE: begin
               if (b == CH_LF || b == CH_CR) begin
                  pending_la = LA_NONE;
                  scan_plain(b);
               end else begin
                  scan_offset++;
               end
            end
            LA_BLOCK, LA_STAR: begin
               scan_offset++;
               if (b == CH_STAR)
                  pending_la = LA_STAR;
               else if (pending_la == LA_STAR && b == CH_SLASH)
                  pending_la = LA_NONE;
               else
                  pending_la = LA_BLOCK;
            end
            LA_QUOTE: begin
               pending_la = LA_NONE;
               if (b == CH_DQUOTE) begin
                  scan_offset++;
                  expect_result(1'b1, b, 1'b0, ERR_NONE, 16'd0, 16'd0);
               end else begin
                  quoting = QM_NONE;
                  scan_plain(b);
               end
            end
            LA_ESC: begin
               pending_la = LA_NONE;
               scan_offset++;
               expect_result(1'b1, b, 1'b0, ERR_NONE, 16'd0, 16'd0);
            end
            default: begin
               pending_la = LA_NONE;
               scan_plain(b);
            end
         endcase
      end
      if (expected_results.size() > count_prior)
         expected_results[expected_results.size() - 1].last_result = 1'b1;
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endfunction

   function automatic void compare_result();
      scan_result_type want;
      if (expected_results.size() == 0) begin
         $error("result beat with no prediction waiting (value_byte %0h, error_code %0d)",
                rsp_mon.value_byte, rsp_mon.error_code);
         error_count++;
         return;
      end
      want = expected_results.pop_front();
      check_field("has_byte", 16'(want.has_byte), 16'(rsp_mon.has_byte));
      check_field("value_byte", 16'(want.value_byte), 16'(rsp_mon.value_byte));
      check_field("terminated", 16'(want.terminated), 16'(rsp_mon.terminated));
      check_field("error_code", 16'(want.error_code), 16'(rsp_mon.error_code));
      check_field("error_pos", want.error_pos, rsp_mon.error_pos);
      check_field("error_len", want.error_len, rsp_mon.error_len);
      check_field("last_result", 16'(want.last_result), 16'(rsp_mon.last_result));
   endfunction

   // results are checked ahead of the same edge's byte prediction
   always @(posedge clock) begin
      if (reset) begin
         expected_results.delete();
         at_mode_copy = 1'b0;
         restart_value();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready)
            compare_result();
         if (csr_mon.valid && csr_mon.ready)
            at_mode_copy = csr_mon.at_mode;
         if (req_mon.valid && req_mon.ready)
            scan_item(req_mon.text_byte, req_mon.end_of_text);
      end
      pending_results = expected_results.size();
   end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench import bqvc_pkg::*; ();

   localparam int CYCLE_LIMIT      = 400000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES    = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bqvc_req_if req_if ();
   bqvc_rsp_if rsp_if ();
   bqvc_csr_if csr_if ();

   int mismatch_total;
   int results_pending;
   int cycle_count   = 0;
   int items_sent    = 0;
   int burst_left    = 0;
   int hold_requests = 0;
   int holds_done    = 0;

   // brackets the generator has opened in the current value
   kind_type open_stack[$];

   always #6 clock = ~clock;

   bracket_quote_value_checker_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   value_scan_checker scan_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_if),
      .rsp_mon         (rsp_if),
      .csr_mon         (csr_if),
      .error_count     (mismatch_total),
      .pending_results (results_pending)
   );

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // receiver: stall pattern that changes now and then, plus requested long holds
   initial begin
      int stall_mode;
      int stall_phase;
      stall_mode    = 0;
      stall_phase   = 0;
      rsp_if.ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_done != hold_requests) begin
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            holds_done++;
         end
         stall_phase++;
         if (stall_phase % 64 == 0)
            stall_mode = $urandom_range(0, 3);
         case (stall_mode)
            0:       rsp_if.ready <= 1'b1;
            1:       rsp_if.ready <= 1'($urandom_range(0, 1));
            2:       rsp_if.ready <= ($urandom_range(0, 5) == 0);
            default: rsp_if.ready <= (stall_phase % 7 < 4);
         endcase
      end
   end

   // one beat on the byte channel; called and left at a falling edge
   task automatic send_item(input logic [7:0] b, input logic eot);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 16);
      end
      req_if.valid       <= 1'b1;
      req_if.text_byte   <= b;
      req_if.end_of_text <= eot;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      burst_left--;
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_item(s[i], 1'b0);
   endtask

   // sender pause until the block has nothing left to give
   task automatic drain();
      req_if.valid <= 1'b0;
      while (results_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      burst_left = 0;
   endtask

   task automatic write_at_mode(input logic value);
      csr_if.valid   <= 1'b1;
      csr_if.at_mode <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   function automatic logic [7:0] opener_of(input kind_type k);
      case (k)
         KIND_PAREN: return CH_LPAREN;
         KIND_BRACK: return CH_LBRACK;
         default:    return CH_LBRACE;
      endcase
   endfunction

   function automatic logic [7:0] closer_of(input kind_type k);
      case (k)
         KIND_PAREN: return CH_RPAREN;
         KIND_BRACK: return CH_RBRACK;
         default:    return CH_RBRACE;
      endcase
   endfunction

   function automatic kind_type random_kind();
      case ($urandom_range(0, 2))
         0:       return KIND_PAREN;
         1:       return KIND_BRACK;
         default: return KIND_BRACE;
      endcase
   endfunction

   // innermost open bracket, taken off the generator stack
   function automatic kind_type take_last_open();
      kind_type k;
      k = open_stack[open_stack.size() - 1];
      open_stack.delete(open_stack.size() - 1);
      return k;
   endfunction

   // any byte the scanner treats as ordinary value content
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      while (b inside {CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR, CH_SPACE, CH_DQUOTE, CH_SQUOTE,
                       CH_LPAREN, CH_RPAREN, CH_STAR, CH_SLASH, CH_SEMI, CH_LBRACK,
                       CH_BSLASH, CH_RBRACK, CH_LBRACE, CH_RBRACE})
         b = 8'($urandom_range(0, 255));
      return b;
   endfunction

   task automatic open_bracket();
      kind_type k;
      k = random_kind();
      open_stack.insert(open_stack.size(), k);
      send_item(opener_of(k), 1'b0);
   endtask

   task automatic send_double_string();
      logic [7:0] b;
      send_item(CH_DQUOTE, 1'b0);
      repeat ($urandom_range(0, 4)) begin
         if ($urandom_range(0, 3) == 0) begin
            send_item(CH_DQUOTE, 1'b0);
            send_item(CH_DQUOTE, 1'b0);
         end else begin
            b = 8'($urandom_range(0, 255));
            while (b == CH_DQUOTE) b = 8'($urandom_range(0, 255));
            send_item(b, 1'b0);
         end
      end
      send_item(CH_DQUOTE, 1'b0);
   endtask

   task automatic send_single_string();
      logic [7:0] b;
      send_item(CH_SQUOTE, 1'b0);
      repeat ($urandom_range(0, 4)) begin
         if ($urandom_range(0, 3) == 0) begin
            send_item(CH_BSLASH, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b0);
         end else begin
            b = 8'($urandom_range(0, 255));
            while (b == CH_SQUOTE || b == CH_BSLASH) b = 8'($urandom_range(0, 255));
            send_item(b, 1'b0);
         end
      end
      send_item(CH_SQUOTE, 1'b0);
   endtask

   task automatic send_comment();
      logic [7:0] b;
      send_item(CH_SLASH, 1'b0);
      if ($urandom_range(0, 1) == 0) begin
         // line comment, closed by a line break
         send_item(CH_SLASH, 1'b0);
         repeat ($urandom_range(0, 3)) begin
            b = 8'($urandom_range(0, 255));
            while (b == CH_LF || b == CH_CR) b = 8'($urandom_range(0, 255));
            send_item(b, 1'b0);
         end
         send_item(($urandom_range(0, 1) == 0) ? CH_LF : CH_CR, 1'b0);
      end else begin
         send_item(CH_STAR, 1'b0);
         repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(0, 3) == 0) begin
               send_item(CH_STAR, 1'b0);
            end else begin
               b = 8'($urandom_range(0, 255));
               while (b == CH_SLASH || b == CH_STAR) b = 8'($urandom_range(0, 255));
               send_item(b, 1'b0);
            end
         end
         send_item(CH_STAR, 1'b0);
         send_item(CH_SLASH, 1'b0);
      end
   endtask

   // one piece of a value
   task automatic send_token();
      case ($urandom_range(0, 9))
         0, 1: repeat ($urandom_range(1, 4)) send_item(plain_byte(), 1'b0);
         2: if (open_stack.size() < 20) open_bracket();
         3: if (open_stack.size() > 0) send_item(closer_of(take_last_open()), 1'b0);
         4: send_double_string();
         5: send_single_string();
         6, 7: send_comment();
         8: begin
            // lone slash
            send_item(CH_SLASH, 1'b0);
            send_item(plain_byte(), 1'b0);
         end
         default: begin
            if (open_stack.size() > 0) begin
               send_item(CH_SEMI, 1'b0);
               open_stack.delete();
            end else if ($urandom_range(0, 3) == 0) begin
               // nest past the stack size
               repeat (STACK_DEPTH_DEFAULT + 1) open_bracket();
            end else begin
               send_item(plain_byte(), 1'b0);
            end
         end
      endcase
   endtask

   task automatic send_terminator();
      case ($urandom_range(0, 7))
         0:       send_item(CH_SPACE, 1'b0);
         1:       send_item(CH_TAB, 1'b0);
         2:       send_item(CH_LF, 1'b0);
         3:       send_item(CH_VT, 1'b0);
         4:       send_item(CH_FF, 1'b0);
         5:       send_item(CH_CR, 1'b0);
         6:       send_item(CH_RBRACK, 1'b0);
         default: send_item(8'($urandom_range(0, 255)), 1'b1);
      endcase
      open_stack.delete();
   endtask

   task automatic send_well_formed_value();
      repeat ($urandom_range(0, 8)) send_token();
      while (open_stack.size() > 0 && $urandom_range(0, 7) != 0)
         send_item(closer_of(take_last_open()), 1'b0);
      send_terminator();
   endtask

   // value cut short by end of text or spoiled by a wrong closer
   task automatic send_broken_value();
      repeat ($urandom_range(0, 3)) send_token();
      case ($urandom_range(0, 5))
         0: begin
            send_item(CH_DQUOTE, 1'b0);
            repeat ($urandom_range(0, 3)) send_item(plain_byte(), 1'b0);
         end
         1: begin
            send_item(CH_SQUOTE, 1'b0);
            send_item(CH_BSLASH, 1'b0);
         end
         2: begin
            send_item(CH_SLASH, 1'b0);
            send_item(CH_STAR, 1'b0);
         end
         3: open_bracket();
         4: send_item(CH_SLASH, 1'b0);
         default: send_item(closer_of(random_kind()), 1'b0);
      endcase
      send_item(8'($urandom_range(0, 255)), 1'b1);
      open_stack.delete();
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 8))
         send_item(8'($urandom_range(0, 255)), ($urandom_range(0, 15) == 0));
      open_stack.delete();
   endtask

   task automatic random_phase(input int count);
      int target;
      int pick;
      target = items_sent + count;
      while (items_sent < target) begin
         pick = $urandom_range(0, 9);
         if (pick < 7)
            send_well_formed_value();
         else if (pick == 7)
            send_noise();
         else
            send_broken_value();
      end
   endtask

   task automatic directed_values();
      // byte extremes, unmatched closer, end by space
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_text(") ");
      // lone slash, then a line comment ended by a line break
      send_text("a/b//x\n");
      // semicolon in brackets, mismatched closer, end at bracket
      send_text("([;{)}]");
      // doubled quote kept, closing quote pending at end of text
      send_text("\"a\"\"b\"");
      send_item(8'h00, 1'b1);
      // escape pending at end of text leaves the string open
      send_text("'\\");
      send_item(8'hFF, 1'b1);
      // open block comment at end of text
      send_text("/*");
      send_item(8'h00, 1'b1);
   endtask

   // stimulus and verdict
   initial begin
      req_if.valid       = 1'b0;
      req_if.text_byte   = 8'h00;
      req_if.end_of_text = 1'b0;
      csr_if.valid       = 1'b0;
      csr_if.at_mode     = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_at_mode(1'b0);
      directed_values();
      drain();

      write_at_mode(1'b1);
      random_phase(110);
      drain();

      // receiver holds off while the sender keeps offering bytes
      write_at_mode(1'b0);
      hold_requests++;
      random_phase(150);
      drain();

      write_at_mode(1'b1);
      random_phase(110);
      drain();

      write_at_mode(1'b0);
      random_phase(80);
      drain();

      if (mismatch_total == 0 && results_pending == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ===== bracket_quote_value_checker_core.f =====
rtl/bqvc_pkg.sv
rtl/bqvc_if.sv
rtl/bqvc_ram.sv
rtl/bqvc_front.sv
rtl/bqvc_queue.sv
rtl/bqvc_back.sv
rtl/bracket_quote_value_checker_core.sv
tb/sv/value_scan_checker.sv
tb/sv/testbench.sv
